// File: rtl/core/aescbc_pkg.sv
// Package: shared types, S-box tables and GF helpers for the AES-128 CBC decryptor.
`timescale 1ns / 1ps
`default_nettype none
package aescbc_pkg;

	localparam logic [1:0] REG_KEY_HIGH = 2'd0;
	localparam logic [1:0] REG_KEY_LOW  = 2'd1;
	localparam logic [1:0] REG_IV_HIGH  = 2'd2;
	localparam logic [1:0] REG_IV_LOW   = 2'd3;

	localparam logic [7:0] RCON_FIRST = 8'h01;
	localparam logic [7:0] RCON_LAST  = 8'h36;
	localparam logic [7:0] GF_POLY    = 8'h1b;
	localparam logic [7:0] GF_MSB     = 8'h80;

	localparam int NumRounds = 10;

	// one classified item travelling from front to back
	typedef struct packed {
		logic [127:0] cipher;
		logic [127:0] feedback;
		logic         last;
	} job_t;

	function automatic logic [7:0] fwd_sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		return t[a];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (((a & GF_MSB) != 8'h00) ? GF_POLY : 8'h00);
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/aescbc_front.sv
// Front end: holds config, chains feedback, queues classified jobs.
`timescale 1ns / 1ps
`default_nettype none
module aescbc_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	input  wire logic [1:0]         cfg_index,
	input  wire logic               cfg_known,
	input  wire logic [63:0]        cfg_data,
	input  wire logic               valid,
	output logic                    stall,
	input  wire logic [63:0]        cipher_high,
	input  wire logic [63:0]        cipher_low,
	input  wire logic               first_block,
	input  wire logic               last_block,
	output logic [127:0]            key,
	output logic                    key_dirty,
	output logic                    job_valid,
	output aescbc_pkg::job_t        job,
	input  wire logic               job_take
);
	logic [127:0] key_q, iv_q, chain_q;
	logic         dirty_q;
	aescbc_pkg::job_t q_mem_q [2];
	logic         wr_q, rd_q;
	logic [1:0]   cnt_q;
	logic         acc;

	assign stall = (cnt_q == 2'd2);
	assign acc = valid && !stall;
	assign key = key_q;
	assign key_dirty = dirty_q;
	assign job_valid = (cnt_q != 2'd0);
	assign job = q_mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			iv_q <= '0;
			chain_q <= '0;
			dirty_q <= 1'b1;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (cfg_valid && cfg_known) begin
				case (cfg_index)
					aescbc_pkg::REG_KEY_HIGH: begin
						key_q[127:64] <= cfg_data;
						dirty_q <= 1'b1;
					end
					aescbc_pkg::REG_KEY_LOW: begin
						key_q[63:0] <= cfg_data;
						dirty_q <= 1'b1;
					end
					aescbc_pkg::REG_IV_HIGH: iv_q[127:64] <= cfg_data;
					aescbc_pkg::REG_IV_LOW: iv_q[63:0] <= cfg_data;
					default: ;
				endcase
			end
			// back end latches the schedule once it begins expanding
			if (job_take) dirty_q <= 1'b0;
			if (acc) begin
				chain_q <= {cipher_high, cipher_low};
				wr_q <= ~wr_q;
			end
			if (job_take) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(acc) - 2'(job_take);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			q_mem_q[wr_q].cipher <= {cipher_high, cipher_low};
			q_mem_q[wr_q].feedback <= first_block ? iv_q : chain_q;
			q_mem_q[wr_q].last <= last_block;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("job queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !job_take)
		else $error("job taken from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (chain_q == $past({cipher_high, cipher_low})))
		else $error("chain feedback not updated");
endmodule
`default_nettype wire

// File: rtl/core/aescbc_back.sv
// Back end: key schedule sequencer and iterative inverse round unit.
`timescale 1ns / 1ps
`default_nettype none
module aescbc_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [127:0]       key,
	input  wire logic               key_dirty,
	input  wire logic               job_valid,
	input  aescbc_pkg::job_t        job,
	output logic                    job_take,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [127:0]            out_data,
	output logic                    out_last
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXP  = 4'b0010,
		ST_RUN  = 4'b0100,
		ST_FIN  = 4'b1000
	} st_t;

	st_t          st_q;
	logic [3:0]   rnd_q;
	logic [127:0] rk_mem_q [11];
	logic [127:0] rk_q, rk_rd_q, st_data_q;
	logic [7:0]   rcon_q;
	aescbc_pkg::job_t job_q;
	logic         ov_q;
	logic [127:0] ov_d_q;
	logic         ol_q;
	logic [127:0] nxt_rk, shsb, mix, rnd_out;
	logic [3:0]   rd_addr;

	// next round key
	always_comb begin
		logic [31:0] t, w0, w1, w2, w3;
		t = rk_q[31:0];
		t = {aescbc_pkg::fwd_sbox(t[23:16]), aescbc_pkg::fwd_sbox(t[15:8]),
			aescbc_pkg::fwd_sbox(t[7:0]), aescbc_pkg::fwd_sbox(t[31:24])}
			^ {rcon_q, 24'h0};
		w0 = rk_q[127:96] ^ t;
		w1 = rk_q[95:64] ^ w0;
		w2 = rk_q[63:32] ^ w1;
		w3 = rk_q[31:0] ^ w2;
		nxt_rk = {w0, w1, w2, w3};
	end

	// inverse shift rows + sub bytes; byte i at bits 127-8i
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				shsb[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] =
					aescbc_pkg::inv_sbox(st_data_q[127 - 8 * (r + 4 * c) -: 8]);
			end
		end
	end

	// add round key then inverse mix columns; the final round (rnd_q zero) skips the mix
	always_comb begin
		logic [127:0] ak;
		logic [7:0] a [4];
		logic [7:0] a2 [4];
		logic [7:0] a4 [4];
		logic [7:0] a8 [4];
		logic [7:0] m9 [4];
		logic [7:0] mb [4];
		logic [7:0] md [4];
		logic [7:0] me [4];
		ak = shsb ^ rk_rd_q;
		for (int c = 0; c < 4; c++) begin
			for (int j = 0; j < 4; j++) begin
				a[j] = ak[127 - 8 * (4 * c + j) -: 8];
				a2[j] = aescbc_pkg::xtime(a[j]);
				a4[j] = aescbc_pkg::xtime(a2[j]);
				a8[j] = aescbc_pkg::xtime(a4[j]);
				m9[j] = a8[j] ^ a[j];
				mb[j] = a8[j] ^ a2[j] ^ a[j];
				md[j] = a8[j] ^ a4[j] ^ a[j];
				me[j] = a8[j] ^ a4[j] ^ a2[j];
			end
			mix[127 - 8 * (4 * c) -: 8]     = me[0] ^ mb[1] ^ md[2] ^ m9[3];
			mix[127 - 8 * (4 * c + 1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
			mix[127 - 8 * (4 * c + 2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
			mix[127 - 8 * (4 * c + 3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
		end
		rnd_out = (rnd_q == 4'd0) ? ak : mix;
	end

	// round key read address runs one ahead of the round counter
	always_comb begin
		rd_addr = 4'(aescbc_pkg::NumRounds);
		if (st_q == ST_RUN) rd_addr = (rnd_q == 4'd0) ? 4'd0 : rnd_q - 4'd1;
	end

	assign job_take = (st_q == ST_IDLE) && job_valid;
	assign out_valid = ov_q;
	assign out_data = ov_d_q;
	assign out_last = ol_q;

	always_ff @(posedge clk) begin
		if (st_q == ST_EXP) rk_mem_q[rnd_q] <= rk_q;
		rk_rd_q <= rk_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			rnd_q <= '0;
			rcon_q <= aescbc_pkg::RCON_FIRST;
			ov_q <= 1'b0;
		end else begin
			if (ov_q && !out_stall) ov_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (job_valid) begin
						job_q <= job;
						if (key_dirty) begin
							rk_q <= key;
							rcon_q <= aescbc_pkg::RCON_FIRST;
							rnd_q <= 4'd0;
							st_q <= ST_EXP;
						end else begin
							st_q <= ST_FIN;
						end
					end
				end
				ST_EXP: begin
					rcon_q <= aescbc_pkg::xtime(rcon_q);
					// rk_q keeps round key 10 once the schedule is done
					if (rnd_q == 4'(aescbc_pkg::NumRounds)) begin
						st_q <= ST_FIN;
					end else begin
						rk_q <= nxt_rk;
						rnd_q <= rnd_q + 4'd1;
					end
				end
				ST_FIN: begin
					// initial key addition with round key 10
					st_data_q <= job_q.cipher ^ rk_q;
					rnd_q <= 4'(aescbc_pkg::NumRounds);
					st_q <= ST_RUN;
				end
				ST_RUN: begin
					if (rnd_q == 4'(aescbc_pkg::NumRounds)) begin
						rnd_q <= rnd_q - 4'd1;
					end else if (rnd_q == 4'd0) begin
						if (!ov_q || !out_stall) begin
							ov_q <= 1'b1;
							ov_d_q <= rnd_out ^ job_q.feedback;
							ol_q <= job_q.last;
							st_q <= ST_IDLE;
						end
					end else begin
						st_data_q <= rnd_out;
						rnd_q <= rnd_q - 4'd1;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_stall) |=> ov_q)
		else $error("result dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		job_take |=> (st_q == ST_EXP || st_q == ST_FIN))
		else $error("job taken without start");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EXP) |-> (rnd_q <= 4'(aescbc_pkg::NumRounds)))
		else $error("schedule overrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EXP && rnd_q == 4'd9) |-> (rcon_q == aescbc_pkg::RCON_LAST))
		else $error("round constant out of step");
endmodule
`default_nettype wire

// File: rtl/core/aes128_cbc_decryptor.sv
// Top level: AES-128 CBC decryptor, front classifier plus iterative back end.
//
//  channel  | dir | handshake             | payload
//  in       | in  | valid / stall (out)   | cipher_high, cipher_low, first_block, last_block
//  out      | out | out_valid / out_stall | plain_high, plain_low, end_of_message
//  cfg      | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A block passes through the back end as job pickup, initial key addition,
// round key fetch, nine full rounds and a final round, after a rebuild of the key
// schedule when the key was written; the single shared round unit and round
// key memory set this.
// The front queue holds two transfers, so the input stalls only when it fills.
// Reset clears the feedback, registers and marks the key schedule stale.
// A result held under out_stall freezes the back end at its final round.
`timescale 1ns / 1ps
`default_nettype none
module aes128_cbc_decryptor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        valid,
	output logic             stall,
	input  wire logic [63:0] cipher_high,
	input  wire logic [63:0] cipher_low,
	input  wire logic        first_block,
	input  wire logic        last_block,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      plain_high,
	output logic [63:0]      plain_low,
	output logic             end_of_message
);
	logic [127:0] key;
	logic         key_dirty, job_valid, job_take;
	aescbc_pkg::job_t job;
	logic [127:0] out_data;

	assign cfg_ready = 1'b1;

	aescbc_front u_front (
		.clk, .arst_n, .cfg_valid, .cfg_index, .cfg_known(1'b1), .cfg_data,
		.valid, .stall, .cipher_high, .cipher_low, .first_block, .last_block,
		.key, .key_dirty, .job_valid, .job, .job_take
	);

	aescbc_back u_back (
		.clk, .arst_n, .key, .key_dirty, .job_valid, .job, .job_take,
		.out_valid, .out_stall, .out_data, .out_last(end_of_message)
	);

	assign plain_high = out_data[127:64];
	assign plain_low  = out_data[63:0];
endmodule
`default_nettype wire
